>>> hdl/utf8d_pkg.sv
// ----------------------------------------------------------------------------
// utf8d_pkg
// Shared types, constants and a helper function for the UTF-8 byte stream decoder.
// ----------------------------------------------------------------------------
package utf8d_pkg;

  // Longest sequence accepted; leads with more leading ones (7..8) are rejected
  localparam int unsigned MAX_SEQ_BYTES = 6;

  localparam logic [7:0] CONT_MARK    = 8'h80;
  localparam logic [5:0] CONT_PAYLOAD = 6'h3f;

  localparam int unsigned CODE_W = 31;
  localparam int unsigned LEN_W  = 3;

  typedef struct packed {
    logic [LEN_W-1:0]  bytes_left;
    logic [LEN_W-1:0]  seq_total;
    logic [CODE_W-1:0] code_accum;
  } state_t;

  typedef struct packed {
    logic [CODE_W-1:0] code_point;
    logic [LEN_W-1:0]  seq_length;
    logic              bad_lead;
  } result_t;

  // Count of leading one bits, 0..8
  function automatic logic [3:0] leading_ones(input logic [7:0] b);
    logic [3:0] n;
    logic       run;
    logic [7:0] probe;
    n     = 4'd0;
    run   = 1'b1;
    probe = CONT_MARK;
    for (int i = 0; i < 8; i++) begin
      if (run && ((b & probe) != 8'h00)) begin
        n = n + 4'd1;
      end else begin
        run = 1'b0;
      end
      probe = probe >> 1;
    end
    return n;
  endfunction

endpackage

>>> hdl/utf8d_step.sv
// ----------------------------------------------------------------------------
// utf8d_step
// Per-word decode: next sequence state and the optional result.
// ----------------------------------------------------------------------------
module utf8d_step (
  input  utf8d_pkg::state_t  state_i,
  input  logic [7:0]         byte_in_i,
  output utf8d_pkg::state_t  state_o,
  output utf8d_pkg::result_t result_o,
  output logic               emit_o
);

  logic [3:0]                   ones;
  logic [3:0]                   len;
  logic [7:0]                   payload;
  logic [utf8d_pkg::CODE_W-1:0] acc_next;
  logic [utf8d_pkg::LEN_W-1:0]  left_next;

  assign ones      = utf8d_pkg::leading_ones(byte_in_i);
  assign len       = (ones == 4'd0) ? 4'd1 : ones;
  assign payload   = byte_in_i & (8'hff >> len);
  assign acc_next  = {state_i.code_accum[utf8d_pkg::CODE_W-7:0],
                      byte_in_i[5:0] & utf8d_pkg::CONT_PAYLOAD};
  assign left_next = state_i.bytes_left - utf8d_pkg::LEN_W'(1);

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    emit_o   = 1'b0;
    if (state_i.bytes_left != '0) begin
      // open sequence: take any word as a continuation
      if (left_next == '0) begin
        emit_o              = 1'b1;
        result_o.code_point = acc_next;
        result_o.seq_length = state_i.seq_total;
        state_o             = '0;
      end else begin
        state_o.bytes_left = left_next;
        state_o.code_accum = acc_next;
      end
    end else if (len > 4'(utf8d_pkg::MAX_SEQ_BYTES)) begin
      emit_o            = 1'b1;
      result_o.bad_lead = 1'b1;
    end else if (len == 4'd1) begin
      // ASCII, or a lone continuation worth its low 7 bits
      emit_o              = 1'b1;
      result_o.code_point = utf8d_pkg::CODE_W'(payload);
      result_o.seq_length = utf8d_pkg::LEN_W'(1);
    end else begin
      state_o.bytes_left = len[utf8d_pkg::LEN_W-1:0] - utf8d_pkg::LEN_W'(1);
      state_o.seq_total  = len[utf8d_pkg::LEN_W-1:0];
      state_o.code_accum = utf8d_pkg::CODE_W'(payload);
    end
  end

endmodule

>>> hdl/utf8_byte_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder_top
// UTF-8 byte stream decoder, sequences of one to six bytes.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with byte_in_i, one byte per word.
// Output channel: out_valid_o / out_stall_i with code_point_o, seq_length_o
// and bad_lead_o, one word per completed sequence or rejected lead byte.
// A word moves at a rising edge with valid high and stall low.
// Throughput: one input byte per cycle while in_stall_o is low, set by
// the single state update between the sequence registers and the result
// register. The result of the byte that completes a sequence appears on
// the output in the cycle after that byte is accepted.
// Bytes in the middle of a sequence give no output word.
// When the receiver stalls, the result register holds its word and the
// input is stalled only while that word is waiting; a new byte is taken
// in the same cycle the held word leaves.
// Reset closes any open sequence and clears the output valid flag; the result register itself is not reset.
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [30:0] code_point_o,
  output logic [2:0]  seq_length_o,
  output logic        bad_lead_o
);

  utf8d_pkg::state_t  state_q, state_d;
  utf8d_pkg::result_t result_q, result_d;
  logic               out_valid_q, out_valid_d;
  logic               emit;
  logic               accept;

  utf8d_step u_step (
    .state_i   (state_q),
    .byte_in_i (byte_in_i),
    .state_o   (state_d),
    .result_o  (result_d),
    .emit_o    (emit)
  );

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (accept && emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        state_q <= state_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = result_q.code_point;
  assign seq_length_o = result_q.seq_length;
  assign bad_lead_o   = result_q.bad_lead;

endmodule
